// ----- design/stdp_pkg.sv -----
// ----------------------------------------------------------------------------
// stdp_pkg
// Shared types, register indexes, controller states and ROM helpers for the
// STDP synapse weight update block.
// ----------------------------------------------------------------------------
package stdp_pkg;

  localparam int SYNAPSES_DEF    = 1024;
  localparam int EXP_ENTRIES_DEF = 256;

  localparam int W_WEIGHT = 16;
  localparam logic [W_WEIGHT-1:0] WEIGHT_MAX = 16'd32768;

  // dividend of the timing divide is |dt| * 16
  localparam int DIVIDEND_W = 20;
  localparam int DIV_CNT_W  = $clog2(DIVIDEND_W + 1);

  localparam logic [1:0] KIND_TIMING = 2'd0;
  localparam logic [1:0] KIND_REWARD = 2'd1;
  localparam logic [1:0] KIND_LOAD   = 2'd2;

  localparam logic [0:0] STATUS_DONE      = 1'b0;
  localparam logic [0:0] STATUS_NOT_FOUND = 1'b1;

  typedef enum logic [2:0] {
    REG_LTP_AMPLITUDE     = 3'd0,
    REG_LTD_AMPLITUDE     = 3'd1,
    REG_LTP_TIME_CONSTANT = 3'd2,
    REG_LTD_TIME_CONSTANT = 3'd3,
    REG_SYNAPSE_COUNT     = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    logic [1:0]         kind;
    logic [9:0]         synapse_index;
    logic signed [15:0] time_difference;
    logic signed [15:0] reward_factor;
    logic [15:0]        load_value;
  } item_t;

  typedef struct packed {
    logic [0:0]  status;
    logic [15:0] old_weight;
    logic [15:0] new_weight;
  } result_t;

  typedef struct packed {
    logic [15:0] ltp_amplitude;
    logic [15:0] ltd_amplitude;
    logic [15:0] ltp_time_constant;
    logic [15:0] ltd_time_constant;
    logic [10:0] synapse_count;
  } cfg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FETCH,
    ST_DIVIDE,
    ST_LOOKUP,
    ST_SCALE,
    ST_APPLY,
    ST_EMIT
  } ctrl_state_t;

  typedef struct packed {
    logic load_item;
    logic read;
    logic start_div;
    logic div_step;
    logic latch_exp;
    logic mul;
    logic apply;
    logic emit;
  } dp_cmd_t;

  typedef struct packed {
    logic found;
    logic timing;
    logic div_last;
    logic out_free;
  } dp_sts_t;

  localparam logic [63:0] Q60_ONE = 64'd1 << 60;

  // series terms 2^60 / (16^k * k!) of exp(-1/16); terms past the ninth are 0
  localparam logic [63:0] EXP_TERM_1 = (Q60_ONE >> 4) / 64'd1;
  localparam logic [63:0] EXP_TERM_2 = (Q60_ONE >> 8) / 64'd2;
  localparam logic [63:0] EXP_TERM_3 = (Q60_ONE >> 12) / 64'd6;
  localparam logic [63:0] EXP_TERM_4 = (Q60_ONE >> 16) / 64'd24;
  localparam logic [63:0] EXP_TERM_5 = (Q60_ONE >> 20) / 64'd120;
  localparam logic [63:0] EXP_TERM_6 = (Q60_ONE >> 24) / 64'd720;
  localparam logic [63:0] EXP_TERM_7 = (Q60_ONE >> 28) / 64'd5040;
  localparam logic [63:0] EXP_TERM_8 = (Q60_ONE >> 32) / 64'd40320;
  localparam logic [63:0] EXP_TERM_9 = (Q60_ONE >> 36) / 64'd362880;

  // exp(-1/16) in Q60
  localparam logic [63:0] EXP_STEP_Q60 = Q60_ONE - EXP_TERM_1 + EXP_TERM_2
                                         - EXP_TERM_3 + EXP_TERM_4 - EXP_TERM_5
                                         + EXP_TERM_6 - EXP_TERM_7 + EXP_TERM_8
                                         - EXP_TERM_9;

  // (a * b) >> 60 for Q60 operands, elaboration only
  function automatic logic [63:0] mul_q60(input logic [63:0] a, input logic [63:0] b);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    return p[123:60];
  endfunction

endpackage

// ----- design/stdp_synapse_weight_update.sv -----
// ----------------------------------------------------------------------------
// stdp_synapse_weight_update
// Pair-based STDP and reward weight update engine over a synapse weight table.
// ----------------------------------------------------------------------------
// Input channel item_valid/item_stall carries one word per update: timing,
// reward or load, addressing one weight entry. Output channel
// result_valid/result_stall returns one word per input word with the old and
// new weight, or a not-found status for an index at or above synapse_count
// capped at SYNAPSES. Configuration writes go through cfg_valid/cfg_ready
// (always ready), indexed by register number; the user must make them while
// the block is idle, which the block itself does not enforce. One word is
// worked at a time. A timing update with nonzero dt goes through fetch, a
// bit-serial divide by the time constant, ROM lookup, multiply, apply and
// emit; other found words skip divide and lookup, not-found ones go to emit.
// Synchronous reset rst loads the register defaults and empties the output
// register; weight entries hold nothing defined until written.
// While result_stall is high the finished word holds in the output register;
// the next input word may be accepted and worked up to its emit step.
// ----------------------------------------------------------------------------
module stdp_synapse_weight_update #(
  parameter int SYNAPSES    = stdp_pkg::SYNAPSES_DEF,
  parameter int EXP_ENTRIES = stdp_pkg::EXP_ENTRIES_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_stall,
  input  stdp_pkg::item_t   item,
  output logic              result_valid,
  input  logic              result_stall,
  output stdp_pkg::result_t result,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [2:0]        cfg_index,
  input  logic [15:0]       cfg_data
);
  import stdp_pkg::*;

  cfg_t    regs;
  dp_cmd_t cmd;
  dp_sts_t sts;

  stdp_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .regs      (regs)
  );

  stdp_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .sts        (sts),
    .cmd        (cmd)
  );

  stdp_dpath #(
    .SYNAPSES    (SYNAPSES),
    .EXP_ENTRIES (EXP_ENTRIES)
  ) u_dpath (
    .clk          (clk),
    .rst          (rst),
    .item         (item),
    .regs         (regs),
    .cmd          (cmd),
    .sts          (sts),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

endmodule

// ----- design/stdp_cfg.sv -----
// ----------------------------------------------------------------------------
// stdp_cfg
// Configuration register file: amplitudes, time constants, synapse count.
// ----------------------------------------------------------------------------
module stdp_cfg (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [2:0]            cfg_index,
  input  logic [15:0]           cfg_data,
  output stdp_pkg::cfg_t        regs
);
  import stdp_pkg::*;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.ltp_amplitude     <= 16'd164;
      regs.ltd_amplitude     <= 16'd197;
      regs.ltp_time_constant <= 16'd320;
      regs.ltd_time_constant <= 16'd320;
      regs.synapse_count     <= 11'd1024;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_LTP_AMPLITUDE:     regs.ltp_amplitude     <= cfg_data;
        REG_LTD_AMPLITUDE:     regs.ltd_amplitude     <= cfg_data;
        REG_LTP_TIME_CONSTANT: regs.ltp_time_constant <= cfg_data;
        REG_LTD_TIME_CONSTANT: regs.ltd_time_constant <= cfg_data;
        REG_SYNAPSE_COUNT:     regs.synapse_count     <= cfg_data[10:0];
        default: ;
      endcase
    end
  end

endmodule

// ----- design/stdp_ctrl.sv -----
// ----------------------------------------------------------------------------
// stdp_ctrl
// Sequencer: fetch, divide, ROM lookup, scale, apply and emit one word.
// ----------------------------------------------------------------------------
module stdp_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_stall,
  input  stdp_pkg::dp_sts_t sts,
  output stdp_pkg::dp_cmd_t cmd
);
  import stdp_pkg::*;

  ctrl_state_t state;
  ctrl_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (item_valid) state_next = ST_FETCH;
      end
      ST_FETCH: begin
        priority if (!sts.found) state_next = ST_EMIT;
        else if (sts.timing)     state_next = ST_DIVIDE;
        else                     state_next = ST_SCALE;
      end
      ST_DIVIDE: begin
        if (sts.div_last) state_next = ST_LOOKUP;
      end
      ST_LOOKUP: state_next = ST_SCALE;
      ST_SCALE:  state_next = ST_APPLY;
      ST_APPLY:  state_next = ST_EMIT;
      ST_EMIT: begin
        if (sts.out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd        = '0;
    item_stall = (state != ST_IDLE);
    unique case (state)
      ST_IDLE:   cmd.load_item = item_valid;
      ST_FETCH: begin
        cmd.read      = 1'b1;
        cmd.start_div = 1'b1;
      end
      ST_DIVIDE: cmd.div_step  = 1'b1;
      ST_LOOKUP: cmd.latch_exp = 1'b1;
      ST_SCALE:  cmd.mul       = 1'b1;
      ST_APPLY:  cmd.apply     = 1'b1;
      ST_EMIT:   cmd.emit      = sts.out_free;
      default: ;
    endcase
  end

endmodule

// ----- design/stdp_dpath.sv -----
// ----------------------------------------------------------------------------
// stdp_dpath
// Weight memory, bit-serial timing divider, exponential ROM, shared
// multiplier, clamp and the result register.
// ----------------------------------------------------------------------------
module stdp_dpath #(
  parameter int SYNAPSES    = stdp_pkg::SYNAPSES_DEF,
  parameter int EXP_ENTRIES = stdp_pkg::EXP_ENTRIES_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  stdp_pkg::item_t   item,
  input  stdp_pkg::cfg_t    regs,
  input  stdp_pkg::dp_cmd_t cmd,
  output stdp_pkg::dp_sts_t sts,
  output logic              result_valid,
  input  logic              result_stall,
  output stdp_pkg::result_t result
);
  import stdp_pkg::*;

  localparam int AW = (SYNAPSES > 1) ? $clog2(SYNAPSES) : 1;
  localparam int EW = (EXP_ENTRIES > 1) ? $clog2(EXP_ENTRIES) : 1;

  typedef logic [16:0] exp_rom_t [EXP_ENTRIES];

  function automatic exp_rom_t build_exp_rom();
    logic [63:0] v;
    exp_rom_t    rom;
    v = Q60_ONE;
    for (int i = 0; i < EXP_ENTRIES; i++) begin
      rom[i] = 17'((v + (64'd1 << 43)) >> 44);
      v      = mul_q60(v, EXP_STEP_Q60);
    end
    return rom;
  endfunction

  localparam exp_rom_t EXP_ROM = build_exp_rom();

  logic [W_WEIGHT-1:0] weight_mem [SYNAPSES];

  item_t                 item_q;
  logic [AW-1:0]         addr_q;
  logic                  found_q;
  logic                  timing_q;
  logic [W_WEIGHT-1:0]   old_q;
  logic [W_WEIGHT-1:0]   new_q;
  logic [15:0]           divisor_q;
  logic [16:0]           rem_q;
  logic [DIVIDEND_W-1:0] quo_q;
  logic [DIV_CNT_W-1:0]  cnt_q;
  logic [16:0]           exp_q;
  logic signed [35:0]    prod_q;

  // lookup against the active synapse count, capped at the store depth
  logic [16:0] count_ext;
  logic [16:0] limit;
  logic        found;

  always_comb begin
    count_ext = 17'(regs.synapse_count);
    limit     = (count_ext < 17'(SYNAPSES)) ? count_ext : 17'(SYNAPSES);
    found     = 17'(item.synapse_index) < limit;
  end

  // timing operands
  logic signed [16:0]    dt_ext;
  logic [16:0]           dt_mag;
  logic                  dt_neg;
  logic [15:0]           tau;
  logic [DIVIDEND_W-1:0] dividend;

  always_comb begin
    dt_ext   = 17'(item_q.time_difference);
    dt_neg   = item_q.time_difference[15];
    dt_mag   = dt_neg ? 17'(-dt_ext) : 17'(dt_ext);
    dividend = {dt_mag[15:0], 4'b0000};
    tau      = dt_neg ? regs.ltd_time_constant : regs.ltp_time_constant;
    if (tau == 16'd0) tau = 16'd1;
  end

  // one quotient bit per step
  logic [16:0] rem_shift;
  logic        rem_ge;

  always_comb begin
    rem_shift = {rem_q[15:0], quo_q[DIVIDEND_W-1]};
    rem_ge    = rem_shift >= {1'b0, divisor_q};
  end

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      item_q   <= item;
      addr_q   <= AW'(item.synapse_index);
      found_q  <= found;
      timing_q <= (item.kind == KIND_TIMING) && (item.time_difference != 16'sd0);
    end
    if (cmd.read) begin
      old_q <= weight_mem[addr_q];
    end
    if (cmd.emit && found_q) begin
      weight_mem[addr_q] <= new_q;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start_div) begin
      divisor_q <= tau;
      rem_q     <= '0;
      quo_q     <= dividend;
      cnt_q     <= DIV_CNT_W'(DIVIDEND_W);
    end else if (cmd.div_step) begin
      rem_q <= rem_ge ? (rem_shift - {1'b0, divisor_q}) : rem_shift;
      quo_q <= {quo_q[DIVIDEND_W-2:0], rem_ge};
      cnt_q <= cnt_q - DIV_CNT_W'(1);
    end
  end

  // m beyond the table reads as zero
  always_ff @(posedge clk) begin
    if (cmd.latch_exp) begin
      exp_q <= (quo_q < DIVIDEND_W'(EXP_ENTRIES)) ? EXP_ROM[quo_q[EW-1:0]] : 17'd0;
    end
  end

  // shared multiplier: amplitude times exponential or reward offset
  logic signed [17:0] mul_a;
  logic signed [17:0] mul_b;
  logic signed [16:0] rw_ext;

  always_comb begin
    rw_ext = 17'(item_q.reward_factor) - 17'sd4096;
    mul_a  = $signed({2'b00, (timing_q && dt_neg) ? regs.ltd_amplitude : regs.ltp_amplitude});
    mul_b  = timing_q ? $signed({1'b0, exp_q}) : 18'(rw_ext);
  end

  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      prod_q <= mul_a * mul_b;
    end
  end

  // add the change and clamp to 0..2.0
  logic signed [23:0] delta;
  logic signed [23:0] base;
  logic signed [23:0] sum;

  always_comb begin
    delta = '0;
    if (timing_q) begin
      delta = dt_neg ? -24'(prod_q >>> 16) : 24'(prod_q >>> 16);
    end else if (item_q.kind == KIND_REWARD) begin
      delta = 24'(prod_q >>> 12);
    end
    base = (item_q.kind == KIND_LOAD) ? $signed({8'd0, item_q.load_value})
                                      : $signed({8'd0, old_q});
    sum  = base + delta;
  end

  always_ff @(posedge clk) begin
    if (cmd.apply) begin
      priority if (sum < 24'sd0)                    new_q <= '0;
      else if (sum > $signed({8'd0, WEIGHT_MAX}))   new_q <= WEIGHT_MAX;
      else                                          new_q <= sum[W_WEIGHT-1:0];
    end
  end

  // output register: hold while stalled
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (cmd.emit) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      if (found_q) begin
        result.status     <= STATUS_DONE;
        result.old_weight <= old_q;
        result.new_weight <= new_q;
      end else begin
        result.status     <= STATUS_NOT_FOUND;
        result.old_weight <= '0;
        result.new_weight <= '0;
      end
    end
  end

  always_comb begin
    sts.found    = found_q;
    sts.timing   = timing_q;
    sts.div_last = (cnt_q == DIV_CNT_W'(1));
    sts.out_free = !result_valid || !result_stall;
  end

endmodule
